FILE: rtl/mct_pkg.sv
// Package for the mm:ss countdown timer: item codes, command type and the
// digit helpers shared by the front decoder and the back executor.
// No dependencies.
`default_nettype none
package mct_pkg;

    localparam int FIFO_DEPTH = 2;

    localparam logic [1:0] OP_KEY     = 2'd0;
    localparam logic [1:0] OP_SECOND  = 2'd1;
    localparam logic [1:0] OP_REFRESH = 2'd2;

    localparam logic [5:0] MAX_VALUE = 6'd59;
    localparam logic [6:0] SEG_OFF   = 7'h7F;

    typedef enum logic [3:0] {
        CMD_DIGIT,
        CMD_PAUSE,
        CMD_CLEAR,
        CMD_BACK,
        CMD_START,
        CMD_ARM,
        CMD_PLUS,
        CMD_TICK,
        CMD_REFRESH,
        CMD_NOP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [3:0] digit;
    } t_cmd;

    localparam int CMD_W = $bits(t_cmd);

    typedef struct packed {
        logic       alarm;
        logic       click;
        logic       paused;
        logic       running;
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [3:0] digit_sel;
        logic [6:0] segments;
    } t_result;

    // keypad layout: 7 8 9 / | 4 5 6 * | 1 2 3 - | C 0 = +
    function automatic t_cmd key_decode(input logic [3:0] pos);
        t_cmd c;
        c.kind  = CMD_DIGIT;
        c.digit = 4'd0;
        case (pos)
            4'd0:    c.digit = 4'd7;
            4'd1:    c.digit = 4'd8;
            4'd2:    c.digit = 4'd9;
            4'd3:    c.kind  = CMD_PAUSE;
            4'd4:    c.digit = 4'd4;
            4'd5:    c.digit = 4'd5;
            4'd6:    c.digit = 4'd6;
            4'd7:    c.kind  = CMD_CLEAR;
            4'd8:    c.digit = 4'd1;
            4'd9:    c.digit = 4'd2;
            4'd10:   c.digit = 4'd3;
            4'd11:   c.kind  = CMD_BACK;
            4'd12:   c.kind  = CMD_START;
            4'd13:   c.digit = 4'd0;
            4'd14:   c.kind  = CMD_ARM;
            default: c.kind  = CMD_PLUS;
        endcase
        return c;
    endfunction

    // tens digit of a value below 64: (v*13)>>7
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [9:0] p;
        p = 10'(v) * 10'd13;
        return 4'(p[9:7]);
    endfunction

    function automatic logic [3:0] ones_of(input logic [5:0] v);
        logic [6:0] t10;
        t10 = 7'(tens_of(v)) * 7'd10;
        return 4'(7'(v) - t10);
    endfunction

    function automatic logic [5:0] sat59(input logic [7:0] v);
        return (v > 8'(MAX_VALUE)) ? MAX_VALUE : v[5:0];
    endfunction

    function automatic logic [6:0] font(input logic [3:0] d);
        logic [6:0] s;
        case (d)
            4'd0:    s = 7'h40;
            4'd1:    s = 7'h79;
            4'd2:    s = 7'h24;
            4'd3:    s = 7'h30;
            4'd4:    s = 7'h19;
            4'd5:    s = 7'h12;
            4'd6:    s = 7'h02;
            4'd7:    s = 7'h78;
            4'd8:    s = 7'h00;
            4'd9:    s = 7'h10;
            default: s = SEG_OFF;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/mct_front.sv
// Front end: takes input requests and classifies them into commands.
// Depends on mct_pkg.
`default_nettype none
module mct_front (
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [1:0]    i_operation,
    input  wire logic [3:0]    i_key_position,
    input  wire logic          i_full,
    output logic               o_push,
    output mct_pkg::t_cmd      o_cmd
);

    always_comb begin
        o_cmd.kind  = mct_pkg::CMD_NOP;
        o_cmd.digit = 4'd0;
        case (i_operation)
            mct_pkg::OP_KEY:     o_cmd = mct_pkg::key_decode(i_key_position);
            mct_pkg::OP_SECOND:  o_cmd.kind = mct_pkg::CMD_TICK;
            mct_pkg::OP_REFRESH: o_cmd.kind = mct_pkg::CMD_REFRESH;
            default:             o_cmd.kind = mct_pkg::CMD_NOP;
        endcase
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

endmodule
`default_nettype wire

FILE: rtl/mct_fifo.sv
// Short command queue between front end and back end.
// Depends on nothing beyond its parameters.
`default_nettype none
module mct_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/mct_back.sv
// Back end: timer state, key/tick/refresh execution and output register.
// Depends on mct_pkg.
`default_nettype none
module mct_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    input  wire mct_pkg::t_cmd i_cmd,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output mct_pkg::t_result o_result
);

    logic [5:0] r_min, n_min;
    logic [5:0] r_sec, n_sec;
    logic       r_active, n_active;
    logic       r_pause, n_pause;
    logic       r_stage, n_stage;
    logic [1:0] r_digits, n_digits;
    logic       r_armed, n_armed;
    logic [1:0] r_scan, n_scan;
    logic [6:0] r_seg, n_seg;
    logic [3:0] r_dig, n_dig;
    logic       r_out_valid;
    mct_pkg::t_result r_out, n_out;

    logic       do_show;
    logic       with_secs;
    logic       n_click;
    logic       n_alarm;
    logic [3:0] shown;

    assign o_pop    = i_cmd_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_min     = r_min;
        n_sec     = r_sec;
        n_active  = r_active;
        n_pause   = r_pause;
        n_stage   = r_stage;
        n_digits  = r_digits;
        n_armed   = r_armed;
        do_show   = 1'b0;
        with_secs = 1'b0;
        n_click   = 1'b0;
        n_alarm   = 1'b0;
        case (i_cmd.kind)
            mct_pkg::CMD_DIGIT: begin
                n_click = 1'b1;
                if (!r_stage) begin
                    if (r_digits == 2'd0) begin
                        n_min    = 6'(i_cmd.digit);
                        n_digits = 2'd1;
                    end else if (r_digits == 2'd1) begin
                        n_min    = mct_pkg::sat59(8'(r_min) * 8'd10 + 8'(i_cmd.digit));
                        n_stage  = 1'b1;
                        n_digits = 2'd0;
                    end
                end else begin
                    if (r_digits == 2'd0) begin
                        n_sec    = mct_pkg::sat59(8'(i_cmd.digit) * 8'd10);
                        n_digits = 2'd1;
                    end else begin
                        n_sec    = mct_pkg::sat59(8'(r_sec) + 8'(i_cmd.digit));
                        n_digits = 2'd0;
                    end
                end
                do_show = 1'b1;
                n_armed = 1'b0;
            end
            mct_pkg::CMD_START: begin
                n_click = 1'b1;
                if (r_armed) begin
                    n_active = 1'b1;
                    n_armed  = 1'b0;
                end
            end
            mct_pkg::CMD_PAUSE: begin
                n_click = 1'b1;
                if (r_active) begin
                    n_pause = !r_pause;
                end
            end
            mct_pkg::CMD_ARM: begin
                n_click = 1'b1;
                if (!r_active && (r_min != '0 || r_sec != '0)) begin
                    n_armed   = 1'b1;
                    do_show   = 1'b1;
                    with_secs = 1'b1;
                end
            end
            mct_pkg::CMD_CLEAR: begin
                n_click  = 1'b1;
                n_min    = '0;
                n_sec    = '0;
                n_stage  = 1'b0;
                n_digits = 2'd0;
                n_active = 1'b0;
                n_pause  = 1'b0;
                n_armed  = 1'b0;
                do_show  = 1'b1;
            end
            mct_pkg::CMD_BACK: begin
                n_click = 1'b1;
                if (r_stage && r_digits != 2'd0) begin
                    n_sec    = 6'(mct_pkg::tens_of(r_sec));
                    n_digits = 2'(r_digits - 1'b1);
                end else if (r_stage) begin
                    n_stage  = 1'b0;
                    n_digits = 2'd2;
                end else if (r_digits != 2'd0) begin
                    n_min    = 6'(mct_pkg::tens_of(r_min));
                    n_digits = 2'(r_digits - 1'b1);
                end
                do_show   = 1'b1;
                with_secs = 1'b1;
                n_armed   = 1'b0;
            end
            mct_pkg::CMD_PLUS: begin
                n_click = 1'b1;
            end
            mct_pkg::CMD_TICK: begin
                if (r_active && !r_pause) begin
                    if (r_sec != '0) begin
                        n_sec = 6'(r_sec - 1'b1);
                    end else if (r_min != '0) begin
                        n_min = 6'(r_min - 1'b1);
                        n_sec = mct_pkg::MAX_VALUE;
                    end else begin
                        n_active = 1'b0;
                        n_alarm  = 1'b1;
                    end
                end
            end
            mct_pkg::CMD_REFRESH: begin
                do_show   = 1'b1;
                with_secs = r_active || r_pause || r_armed;
            end
            default: begin
            end
        endcase
    end

    // display scan uses the updated time
    always_comb begin
        case (r_scan)
            2'd0:    shown = mct_pkg::tens_of(n_min);
            2'd1:    shown = mct_pkg::ones_of(n_min);
            2'd2:    shown = with_secs ? mct_pkg::tens_of(n_sec) : 4'd0;
            default: shown = with_secs ? mct_pkg::ones_of(n_sec) : 4'd0;
        endcase
        n_seg  = r_seg;
        n_dig  = r_dig;
        n_scan = r_scan;
        if (do_show) begin
            n_seg  = mct_pkg::font(shown);
            n_dig  = 4'(4'b0001 << r_scan);
            n_scan = 2'(r_scan + 1'b1);
        end
        n_out.segments  = n_seg;
        n_out.digit_sel = n_dig;
        n_out.minutes   = n_min;
        n_out.seconds   = n_sec;
        n_out.running   = n_active;
        n_out.paused    = n_pause;
        n_out.click     = n_click;
        n_out.alarm     = n_alarm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= '0;
            r_sec       <= '0;
            r_active    <= 1'b0;
            r_pause     <= 1'b0;
            r_stage     <= 1'b0;
            r_digits    <= 2'd0;
            r_armed     <= 1'b0;
            r_scan      <= 2'd0;
            r_seg       <= mct_pkg::SEG_OFF;
            r_dig       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_min       <= n_min;
                r_sec       <= n_sec;
                r_active    <= n_active;
                r_pause     <= n_pause;
                r_stage     <= n_stage;
                r_digits    <= n_digits;
                r_armed     <= n_armed;
                r_scan      <= n_scan;
                r_seg       <= n_seg;
                r_dig       <= n_dig;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/mmss_countdown_timer_keypad.sv
// Top level of the mm:ss keypad countdown timer: front decoder, command
// queue and back executor. Depends on mct_pkg, mct_front, mct_fifo, mct_back.
//
//  channel   | direction | tdata                       | tuser
//  ----------+-----------+-----------------------------+----------------
//  s_axis    | in        | key_position [3:0]          | operation [1:0]
//  m_axis    | out       | result, see port comment    | -
//
// One request per cycle sustained unless the output stalls; each request
// gives one result, decoded into the queue, then executed into the output
// register. Synchronous active-low reset clears the timer to 00:00 with the
// display blanked. A stalled output fills the queue, then s_axis_tready drops.
`default_nettype none
module mmss_countdown_timer_keypad #(
    parameter int FIFO_DEPTH = mct_pkg::FIFO_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [3:0] key_position, [7:4] zero
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [6:0] segment_pattern, [10:7] digit_select, [16:11] minutes_now,
    // [22:17] seconds_now, [23] running, [24] is_paused, [25] click,
    // [26] alarm, [31:27] zero
    output logic [31:0]      m_axis_tdata
);

    logic                     fifo_full;
    logic                     fifo_valid;
    logic                     push;
    logic                     pop;
    mct_pkg::t_cmd            front_cmd;
    logic [mct_pkg::CMD_W-1:0] head_bits;
    mct_pkg::t_result         result;

    mct_front u_front (
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_operation    (s_axis_tuser),
        .i_key_position (s_axis_tdata[3:0]),
        .i_full         (fifo_full),
        .o_push         (push),
        .o_cmd          (front_cmd)
    );

    mct_fifo #(
        .WIDTH (mct_pkg::CMD_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (fifo_full),
        .o_valid (fifo_valid),
        .i_pop   (pop),
        .o_data  (head_bits)
    );

    mct_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (fifo_valid),
        .i_cmd       (mct_pkg::t_cmd'(head_bits)),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (result)
    );

    assign m_axis_tdata = {5'd0, result};

    ap_alarm_stops : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && result.alarm) |-> !result.running)
        else $error("alarm reported while still running");

    ap_pause_needs_run : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && result.paused) |-> result.running)
        else $error("paused without running");

    ap_digit_onehot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot0(result.digit_sel))
        else $error("digit select not one-hot");

    ap_full_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!s_axis_tready && $past(i_rst_n)) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("queue full without output stall");

endmodule
`default_nettype wire
